@@ hdl/lpr_pkg.sv @@
// Shared types, constants and codes of the IPv4 longest-prefix router.
`default_nettype none
package lpr_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned IFACE_W     = 4;
  localparam int unsigned TTL_W       = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned IFACE_COUNT_DEF = 16;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef enum logic {
    CMD_ADD     = 1'b0,
    CMD_FORWARD = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_FORWARDED   = 3'd1,
    ST_TTL_EXPIRED = 3'd2,
    ST_NO_ROUTE    = 3'd3,
    ST_TABLE_FULL  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE,
    S_DONE
  } state_e;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic               has_hop;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
  } entry_t;

  // Running best-match state handed to the compare unit.
  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] len;
  } best_t;

endpackage
`default_nettype wire

@@ hdl/lpr_if.sv @@
// Valid/ready channel interfaces for router commands and results.
`default_nettype none
interface lpr_in_if import lpr_pkg::*;;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [ADDR_W-1:0]  new_prefix;
  logic [LEN_W-1:0]   new_prefix_len;
  logic               new_hop_valid;
  logic [ADDR_W-1:0]  new_hop_addr;
  logic [IFACE_W-1:0] new_iface;
  logic [ADDR_W-1:0]  dest_addr;
  logic [TTL_W-1:0]   ttl_in;

  modport source (
    output valid, cmd, new_prefix, new_prefix_len, new_hop_valid, new_hop_addr,
           new_iface, dest_addr, ttl_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, new_prefix, new_prefix_len, new_hop_valid, new_hop_addr,
           new_iface, dest_addr, ttl_in,
    output ready
  );
endinterface

interface lpr_out_if import lpr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IFACE_W-1:0]  out_iface;
  logic [ADDR_W-1:0]   hop_addr;
  logic [TTL_W-1:0]    ttl_out;

  modport source (
    output valid, status, out_iface, hop_addr, ttl_out,
    input  ready
  );
  modport sink (
    input  valid, status, out_iface, hop_addr, ttl_out,
    output ready
  );
endinterface
`default_nettype wire

@@ hdl/lpr_match.sv @@
// Shared prefix compare unit: masked address match and length priority.
`default_nettype none
module lpr_match import lpr_pkg::*; (
  input  entry_t            entry_i,
  input  logic [ADDR_W-1:0] dest_i,
  input  best_t             best_i,
  output logic              hit_o
);

  logic [ADDR_W-1:0] mask;
  logic              addr_eq;

  // top len bits set; len 0 gives an empty mask, len 32 a full one
  assign mask    = ~({ADDR_W{1'b1}} >> entry_i.len);
  assign addr_eq = ((entry_i.prefix ^ dest_i) & mask) == '0;
  // >= so that a later route of equal length takes over
  assign hit_o   = addr_eq && (!best_i.found || entry_i.len >= best_i.len);

endmodule
`default_nettype wire

@@ hdl/ipv4_longest_prefix_router.sv @@
// Top level of the IPv4 longest-prefix-match router.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in_i    | in  | valid/ready        | cmd, route fields (add), dest + ttl (fwd)
//  out_o   | out | valid/ready        | status, out_iface, hop_addr, ttl_out
//
// Flow: an add, an expired TTL or a forward on an empty table goes straight to
//   the done state, and its result is then loaded into the output register. A forward
//   scans its stored routes: the single read port of the route memory delivers one
//   route per cycle to the shared compare unit; the drain and resolve states follow.
// One item at a time: in_i.ready is high only while idle.
// Stalls: a result waits in the output register; the next item is taken as soon
//   as that result has been loaded there, and only the finished one after it waits.
// Reset clears the route count; the route memory itself is never cleared.
`default_nettype none
module ipv4_longest_prefix_router import lpr_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned IFACE_COUNT = IFACE_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lpr_in_if.sink        in_i,
  lpr_out_if.source     out_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e state_q, state_d;

  // route memory, single write port, one registered read port
  entry_t rt_mem_q [TABLE_DEPTH];
  entry_t rd_q;
  logic   rd_vld_q;

  logic [CW-1:0] count_q;
  logic [IW-1:0] idx_q;

  // item under work
  logic [ADDR_W-1:0] dest_q;
  logic [TTL_W-1:0]  ttl_q;

  // best match so far
  best_t              best_q;
  logic               best_has_hop_q;
  logic [ADDR_W-1:0]  best_hop_q;
  logic [IFACE_W-1:0] best_iface_q;

  // finished result, then output register
  status_e            res_status_q;
  logic [IFACE_W-1:0] res_iface_q;
  logic [ADDR_W-1:0]  res_hop_q;
  logic [TTL_W-1:0]   res_ttl_q;

  logic                out_vld_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [IFACE_W-1:0]  out_iface_q;
  logic [ADDR_W-1:0]   out_hop_q;
  logic [TTL_W-1:0]    out_ttl_q;

  logic   in_fire, full, is_add, ttl_dead, last_issue, rd_en, out_free, out_load;
  logic   hit;
  entry_t wr_entry;
  logic [LEN_W-1:0] len_sat;

  assign in_fire  = in_i.valid && in_i.ready;
  assign full     = count_q == CW'(TABLE_DEPTH);
  assign is_add   = in_i.cmd == CMD_ADD;
  assign ttl_dead = in_i.ttl_in <= TTL_W'(1);
  assign last_issue = CW'(idx_q) == (count_q - CW'(1));
  assign out_free = !out_vld_q || out_o.ready;

  // lengths above 32 are stored as 32
  assign len_sat = (in_i.new_prefix_len > MAX_LEN) ? MAX_LEN : in_i.new_prefix_len;
  assign wr_entry = '{prefix:  in_i.new_prefix,
                      len:     len_sat,
                      has_hop: in_i.new_hop_valid,
                      hop:     in_i.new_hop_addr,
                      iface:   in_i.new_iface};

  lpr_match u_match (
    .entry_i (rd_q),
    .dest_i  (dest_q),
    .best_i  (best_q),
    .hit_o   (hit)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (is_add || ttl_dead || count_q == '0) state_d = S_DONE;
          else                                     state_d = S_SCAN;
        end
      end
      S_SCAN:    if (last_issue) state_d = S_DRAIN;
      S_DRAIN:   state_d = S_RESOLVE;
      S_RESOLVE: state_d = S_DONE;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = state_q == S_IDLE;
    rd_en      = state_q == S_SCAN;
    out_load   = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (in_fire && is_add && !full) count_q <= count_q + CW'(1);
      if (out_load)          out_vld_q <= 1'b1;
      else if (out_o.ready)  out_vld_q <= 1'b0;
    end
  end

  // ---------------- route memory ----------------
  always_ff @(posedge clk_i) begin
    if (in_fire && is_add && !full) rt_mem_q[count_q[IW-1:0]] <= wr_entry;
    if (rd_en) rd_q <= rt_mem_q[idx_q];
  end

  // ---------------- scan datapath ----------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dest_q <= in_i.dest_addr;
      ttl_q  <= in_i.ttl_in;
      idx_q  <= '0;
      best_q <= '{found: 1'b0, len: '0};
    end else if (rd_en) begin
      idx_q <= idx_q + IW'(1);
    end
    if (rd_vld_q && hit) begin
      best_q         <= '{found: 1'b1, len: rd_q.len};
      best_has_hop_q <= rd_q.has_hop;
      best_hop_q     <= rd_q.hop;
      best_iface_q   <= rd_q.iface;
    end
  end

  // ---------------- result ----------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_iface_q <= '0;
      res_hop_q   <= '0;
      res_ttl_q   <= '0;
      if (is_add)              res_status_q <= full ? ST_TABLE_FULL : ST_ADDED;
      else if (ttl_dead)       res_status_q <= ST_TTL_EXPIRED;
      else                     res_status_q <= ST_NO_ROUTE;
    end else if (state_q == S_RESOLVE) begin
      if (best_q.found && (32'(best_iface_q) < 32'(IFACE_COUNT))) begin
        res_status_q <= ST_FORWARDED;
        res_iface_q  <= best_iface_q;
        res_hop_q    <= best_has_hop_q ? best_hop_q : dest_q;
        res_ttl_q    <= ttl_q - TTL_W'(1);
      end else begin
        res_status_q <= ST_NO_ROUTE;
      end
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_iface_q  <= res_iface_q;
      out_hop_q    <= res_hop_q;
      out_ttl_q    <= res_ttl_q;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.status    = out_status_q;
  assign out_o.out_iface = out_iface_q;
  assign out_o.hop_addr  = out_hop_q;
  assign out_o.ttl_out   = out_ttl_q;

`ifndef SYNTHESIS
  // route count never runs past the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TABLE_DEPTH)
    else $error("route count exceeds table depth");

  // a stored route bumps the count by exactly one
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_add && !full) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("add did not advance route count");

  // a finished result holds while the output register is still occupied
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_vld_q && !out_o.ready) |=> (state_q == S_DONE))
    else $error("result left while output register busy");

  // scan reads only occupied slots
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (CW'(idx_q) < count_q))
    else $error("scan index beyond stored routes");
`endif

endmodule
`default_nettype wire
